[rtl/mecanum_wheel_speed_limiter_unit_defines.svh]
// Assertion macros shared by the speed limiter RTL.
`ifndef MECANUM_WHEEL_SPEED_LIMITER_UNIT_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_LIMITER_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define MWSL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define MWSL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mwsl_pkg.sv]
package mwsl_pkg;

    localparam int MAG_W     = 15;
    localparam int LIN_W     = 31;
    localparam int LMAG_W    = 30;
    localparam int PROD_W    = 46;
    localparam int FRAC_DROP = 24;
    localparam int ACC_W     = 2 * MAG_W;
    localparam int DIV_STEPS = MAG_W;
    localparam int NUM_WHEELS = 4;

    localparam logic [MAG_W-1:0] SPEED_SAT = 15'h7FFF;

    localparam logic [11:0] LEVER_RESET = 12'd800;
    localparam logic [15:0] GAIN_RESET  = 16'd4096;
    localparam logic [14:0] LIMIT_RESET = 15'd8000;

    typedef enum logic [1:0] {
        REG_LEVER = 2'd0,
        REG_GAIN  = 2'd1,
        REG_LIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
    } in_t;

    typedef struct packed {
        logic signed [15:0] wheel_one_speed;
        logic signed [15:0] wheel_two_speed;
        logic signed [15:0] wheel_three_speed;
        logic signed [15:0] wheel_four_speed;
        logic               was_limited;
    } out_t;

    typedef struct packed {
        logic [11:0] lever_arm_sum;
        logic [15:0] speed_gain;
        logic [14:0] speed_limit;
    } cfg_t;

    // Classified command: output sign and saturated magnitude per wheel
    typedef struct packed {
        logic [NUM_WHEELS-1:0]            neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]                 max_mag;
        logic                             limited;
    } cls_t;

    typedef struct packed {
        logic valid;
        cls_t item;
    } push_t;

endpackage

[rtl/mwsl_front.sv]
module mwsl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  mwsl_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  mwsl_pkg::in_t   in_data,
    output mwsl_pkg::push_t push,
    input  logic            full
);

    localparam int NW = mwsl_pkg::NUM_WHEELS;

    logic adv;

    logic                     s1_valid_reg;
    logic signed [15:0]       s1_x_reg;
    logic signed [15:0]       s1_y_reg;
    logic signed [28:0]       s1_rl_reg;
    logic signed [28:0]       s1_rl_next;

    logic                                      s2_valid_reg;
    logic [NW-1:0]                             s2_neg_reg;
    logic [NW-1:0][mwsl_pkg::LMAG_W-1:0]       s2_mag_reg;
    logic [NW-1:0]                             s2_neg_next;
    logic [NW-1:0][mwsl_pkg::LMAG_W-1:0]       s2_mag_next;

    logic                                      s3_valid_reg;
    logic [NW-1:0]                             s3_neg_reg;
    logic [NW-1:0][mwsl_pkg::PROD_W-1:0]       s3_prod_reg;

    logic                                      s4_valid_reg;
    logic [NW-1:0]                             s4_neg_reg;
    logic [NW-1:0][mwsl_pkg::MAG_W-1:0]        s4_mag_reg;
    logic [NW-1:0]                             s4_neg_next;
    logic [NW-1:0][mwsl_pkg::MAG_W-1:0]        s4_mag_next;

    logic                  s5_valid_reg;
    mwsl_pkg::cls_t        s5_item_reg;
    mwsl_pkg::cls_t        s5_item_next;

    logic signed [mwsl_pkg::LIN_W-1:0] xs;
    logic signed [mwsl_pkg::LIN_W-1:0] ys;
    logic signed [mwsl_pkg::LIN_W-1:0] rl;
    logic signed [mwsl_pkg::LIN_W-1:0] dif_xy;
    logic signed [mwsl_pkg::LIN_W-1:0] sum_xy;
    logic signed [mwsl_pkg::LIN_W-1:0] lin [NW];
    logic [mwsl_pkg::LIN_W-1:0]        lin_abs [NW];
    logic [mwsl_pkg::PROD_W-mwsl_pkg::FRAC_DROP-1:0] scaled [NW];
    logic [mwsl_pkg::MAG_W-1:0] max_a;
    logic [mwsl_pkg::MAG_W-1:0] max_b;

    // Advance unless the last stage holds an item the queue cannot take
    assign adv      = !(s5_valid_reg && full);
    assign in_stall = !adv;

    assign push.valid = s5_valid_reg && !full;
    assign push.item  = s5_item_reg;

    assign s1_rl_next = in_data.yaw_rate * $signed({1'b0, cfg.lever_arm_sum});

    always_comb
    begin
        xs     = mwsl_pkg::LIN_W'($signed({s1_x_reg, 12'd0}));
        ys     = mwsl_pkg::LIN_W'($signed({s1_y_reg, 12'd0}));
        rl     = mwsl_pkg::LIN_W'(s1_rl_reg);
        dif_xy = xs - ys;
        sum_xy = xs + ys;
        lin[0] = dif_xy + rl;
        lin[1] = sum_xy - rl;
        lin[2] = sum_xy + rl;
        lin[3] = dif_xy - rl;
        for (int i = 0; i < NW; i++)
        begin
            s2_neg_next[i] = lin[i][mwsl_pkg::LIN_W-1];
            lin_abs[i]     = s2_neg_next[i] ? -lin[i] : lin[i];
            s2_mag_next[i] = lin_abs[i][mwsl_pkg::LMAG_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            scaled[i] = s3_prod_reg[i][mwsl_pkg::PROD_W-1:mwsl_pkg::FRAC_DROP];
            if (|scaled[i][mwsl_pkg::PROD_W-mwsl_pkg::FRAC_DROP-1:mwsl_pkg::MAG_W])
                s4_mag_next[i] = mwsl_pkg::SPEED_SAT;
            else
                s4_mag_next[i] = scaled[i][mwsl_pkg::MAG_W-1:0];
        end
        // Motor sign pattern: wheels one and three turn the other way
        s4_neg_next[0] = !s3_neg_reg[0];
        s4_neg_next[1] =  s3_neg_reg[1];
        s4_neg_next[2] = !s3_neg_reg[2];
        s4_neg_next[3] =  s3_neg_reg[3];
    end

    always_comb
    begin
        max_a = (s4_mag_reg[0] > s4_mag_reg[1]) ? s4_mag_reg[0] : s4_mag_reg[1];
        max_b = (s4_mag_reg[2] > s4_mag_reg[3]) ? s4_mag_reg[2] : s4_mag_reg[3];
        s5_item_next.neg     = s4_neg_reg;
        s5_item_next.mag     = s4_mag_reg;
        s5_item_next.max_mag = (max_a > max_b) ? max_a : max_b;
        s5_item_next.limited = s5_item_next.max_mag > cfg.speed_limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= in_data.vel_x;
            s1_y_reg    <= in_data.vel_y;
            s1_rl_reg   <= s1_rl_next;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
            s3_neg_reg  <= s2_neg_reg;
            for (int i = 0; i < NW; i++)
            begin
                s3_prod_reg[i] <= mwsl_pkg::PROD_W'(s2_mag_reg[i])
                                * mwsl_pkg::PROD_W'(cfg.speed_gain);
            end
            s4_neg_reg  <= s4_neg_next;
            s4_mag_reg  <= s4_mag_next;
            s5_item_reg <= s5_item_next;
        end
    end

endmodule

[rtl/mwsl_queue.sv]
`include "mecanum_wheel_speed_limiter_unit_defines.svh"

module mwsl_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mwsl_pkg::push_t push,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output mwsl_pkg::cls_t  q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwsl_pkg::cls_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign q_valid   = (count_reg != '0);
    assign q_item    = mem_reg[rd_ptr_reg];
    assign push_fire = push.valid && !full;
    assign pop_fire  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (!push_fire && pop_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push.item;
    end

    `MWSL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `MWSL_ASSERT_IMP(a_no_push_full, push.valid, !full, "front pushed into a full queue")

endmodule

[rtl/mwsl_back.sv]
`include "mecanum_wheel_speed_limiter_unit_defines.svh"

module mwsl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [14:0]    speed_limit,
    input  logic           q_valid,
    input  mwsl_pkg::cls_t q_item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output mwsl_pkg::out_t out_data
);

    localparam int NW    = mwsl_pkg::NUM_WHEELS;
    localparam int MW    = mwsl_pkg::MAG_W;
    localparam int AW    = mwsl_pkg::ACC_W;
    localparam int STEPS = mwsl_pkg::DIV_STEPS;
    localparam int LAST  = STEPS - 1;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                               input logic [MW-1:0] dsr);
        logic [MW:0] trial;
        logic        qbit;
        trial = acc[AW-1:MW-1];
        qbit  = (trial >= {1'b0, dsr});
        if (qbit)
            trial = trial - {1'b0, dsr};
        return {trial[MW-1:0], acc[MW-2:0], qbit};
    endfunction

    logic adv;

    logic                    b0_valid_reg;
    logic [NW-1:0]           b0_neg_reg;
    logic [NW-1:0][AW-1:0]   b0_acc_reg;
    logic [MW-1:0]           b0_dsr_reg;
    logic                    b0_lim_reg;
    logic [MW-1:0]           mul_op;

    logic                    dv_valid_reg [STEPS];
    logic [NW-1:0]           dv_neg_reg   [STEPS];
    logic [NW-1:0][AW-1:0]   dv_acc_reg   [STEPS];
    logic [NW-1:0][AW-1:0]   dv_acc_next  [STEPS];
    logic [MW-1:0]           dv_dsr_reg   [STEPS];
    logic                    dv_lim_reg   [STEPS];

    logic                    out_valid_reg;
    mwsl_pkg::out_t          out_data_reg;
    mwsl_pkg::out_t          out_data_next;
    logic [MW-1:0]           quo [NW];
    logic                    over_lim;

    assign adv       = !(out_valid_reg && out_stall);
    assign pop       = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Unlimited items divide by one so every item takes the same path
    assign mul_op = q_item.limited ? speed_limit : MW'(1);

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            for (int l = 0; l < NW; l++)
            begin
                if (k == 0)
                    dv_acc_next[k][l] = div_step(b0_acc_reg[l], b0_dsr_reg);
                else
                    dv_acc_next[k][l] = div_step(dv_acc_reg[k-1][l], dv_dsr_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        over_lim = 1'b0;
        for (int l = 0; l < NW; l++)
        begin
            quo[l] = dv_acc_reg[LAST][l][MW-1:0];
            if (quo[l] > speed_limit)
                over_lim = 1'b1;
        end
        out_data_next.wheel_one_speed   = dv_neg_reg[LAST][0] ? -$signed({1'b0, quo[0]})
                                                              :  $signed({1'b0, quo[0]});
        out_data_next.wheel_two_speed   = dv_neg_reg[LAST][1] ? -$signed({1'b0, quo[1]})
                                                              :  $signed({1'b0, quo[1]});
        out_data_next.wheel_three_speed = dv_neg_reg[LAST][2] ? -$signed({1'b0, quo[2]})
                                                              :  $signed({1'b0, quo[2]});
        out_data_next.wheel_four_speed  = dv_neg_reg[LAST][3] ? -$signed({1'b0, quo[3]})
                                                              :  $signed({1'b0, quo[3]});
        out_data_next.was_limited       = dv_lim_reg[LAST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < STEPS; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg    <= q_valid;
            dv_valid_reg[0] <= b0_valid_reg;
            for (int k = 1; k < STEPS; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            out_valid_reg   <= dv_valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_neg_reg <= q_item.neg;
            b0_dsr_reg <= q_item.limited ? q_item.max_mag : MW'(1);
            b0_lim_reg <= q_item.limited;
            for (int l = 0; l < NW; l++)
                b0_acc_reg[l] <= AW'(q_item.mag[l]) * AW'(mul_op);
            dv_neg_reg[0] <= b0_neg_reg;
            dv_dsr_reg[0] <= b0_dsr_reg;
            dv_lim_reg[0] <= b0_lim_reg;
            for (int k = 1; k < STEPS; k++)
            begin
                dv_neg_reg[k] <= dv_neg_reg[k-1];
                dv_dsr_reg[k] <= dv_dsr_reg[k-1];
                dv_lim_reg[k] <= dv_lim_reg[k-1];
            end
            for (int k = 0; k < STEPS; k++)
                dv_acc_reg[k] <= dv_acc_next[k];
            out_data_reg <= out_data_next;
        end
    end

    `MWSL_ASSERT_IMP(a_rescale_in_limit, dv_valid_reg[LAST] && dv_lim_reg[LAST], !over_lim, "rescaled speed above limit")
    `MWSL_ASSERT_NXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg && $stable(out_data_reg), "stalled result changed")

endmodule

[rtl/mecanum_wheel_speed_limiter_unit.sv]
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-----------------------------------------
// in       | in_valid / in_stall         | in_data  (vel_x, vel_y, yaw_rate)
// out      | out_valid / out_stall       | out_data (four wheel speeds, was_limited)
// cfg      | psel / penable / pwrite     | paddr, pwdata, prdata, pready
//
// One command per cycle when the output is not stalled; on its way a command passes through
// a 5-stage mixing and scaling front, the queue, a multiply stage and a 15-stage divider.
// Reset clears all valid flags and the queue and loads the register defaults.
// A stalled output freezes the back end only; the front keeps filling the queue and
// stalls its input once the queue is full.
module mecanum_wheel_speed_limiter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  mwsl_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output mwsl_pkg::out_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    mwsl_pkg::cfg_t     cfg_reg;
    mwsl_pkg::reg_idx_t reg_idx;
    mwsl_pkg::push_t    push;
    mwsl_pkg::cls_t     q_item;
    logic               full;
    logic               q_valid;
    logic               pop;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = mwsl_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lever_arm_sum <= mwsl_pkg::LEVER_RESET;
            cfg_reg.speed_gain    <= mwsl_pkg::GAIN_RESET;
            cfg_reg.speed_limit   <= mwsl_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mwsl_pkg::REG_LEVER: cfg_reg.lever_arm_sum <= pwdata[11:0];
                mwsl_pkg::REG_GAIN:  cfg_reg.speed_gain    <= pwdata[15:0];
                mwsl_pkg::REG_LIMIT: cfg_reg.speed_limit   <= pwdata[14:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mwsl_pkg::REG_LEVER: prdata = {20'd0, cfg_reg.lever_arm_sum};
            mwsl_pkg::REG_GAIN:  prdata = {16'd0, cfg_reg.speed_gain};
            mwsl_pkg::REG_LIMIT: prdata = {17'd0, cfg_reg.speed_limit};
            default:             prdata = '0;
        endcase
    end

    mwsl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .full     (full)
    );

    mwsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    mwsl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .speed_limit (cfg_reg.speed_limit),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
